// ----- rtl/random_permutation_generator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the random permutation generator
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PERMUTATION_GENERATOR_UNIT_MACROS_SVH
`define RANDOM_PERMUTATION_GENERATOR_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define RPG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/rpg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_pkg
// Shared types and constants of the random permutation generator.
// ----------------------------------------------------------------------------
package rpg_pkg;

  localparam int unsigned MaxLen   = 64;
  localparam int unsigned LenW     = 7;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned WordW    = 64;
  localparam int unsigned CfgIdxW  = 4;

  localparam logic [CfgIdxW-1:0] RegSeedLow  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSeedHigh = CfgIdxW'(1);

  localparam logic [WordW-1:0] SeedLowRst  = WordW'(1);
  localparam logic [WordW-1:0] SeedHighRst = WordW'(0);

  // xoroshiro128+ constants
  localparam int unsigned RotA   = 24;
  localparam int unsigned RotB   = 37;
  localparam int unsigned ShiftA = 16;

  // remainder unit: bits folded in per cycle
  localparam int unsigned ModBitsPerCyc = 8;
  localparam int unsigned ModCycles     = WordW / ModBitsPerCyc;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  typedef logic [MaxLen-1:0][IdxW-1:0] mod_table_t;

  // entry i holds (2^64-1) mod (i+1); evaluated at elaboration only
  function automatic mod_table_t build_all_ones_mod();
    mod_table_t tab;
    int unsigned rem;
    int unsigned b;
    for (int i = 0; i < MaxLen; i++) begin
      b   = i + 1;
      rem = 0;
      for (int k = 0; k < WordW; k++) begin
        rem = rem * 2 + 1;
        if (rem >= b) begin
          rem = rem - b;
        end
      end
      tab[i] = IdxW'(rem);
    end
    return tab;
  endfunction

  localparam mod_table_t AllOnesMod = build_all_ones_mod();

endpackage

// ----- rtl/rpg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rpg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rpg_rng.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_rng
// xoroshiro128+ generator; each advance registers one 64-bit draw.
// ----------------------------------------------------------------------------
module rpg_rng import rpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  logic               advance_i,
  output logic [WordW-1:0]   draw_o
);

  logic [WordW-1:0] word_a_q, word_a_d;
  logic [WordW-1:0] word_b_q, word_b_d;
  logic [WordW-1:0] draw_q;
  logic [WordW-1:0] mix;

  assign mix = word_a_q ^ word_b_q;

  always_comb begin
    word_a_d = word_a_q;
    word_b_d = word_b_q;
    if (cfg_we_i) begin
      if (cfg_index_i == RegSeedLow) begin
        word_a_d = cfg_data_i;
      end
      if (cfg_index_i == RegSeedHigh) begin
        word_b_d = cfg_data_i;
      end
    end else if (advance_i) begin
      word_a_d = {word_a_q[WordW-1-RotA:0], word_a_q[WordW-1:WordW-RotA]}
               ^ mix ^ (mix << ShiftA);
      word_b_d = {mix[WordW-1-RotB:0], mix[WordW-1:WordW-RotB]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_a_q <= SeedLowRst;
      word_b_q <= SeedHighRst;
    end else begin
      word_a_q <= word_a_d;
      word_b_q <= word_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && !cfg_we_i) begin
      draw_q <= word_a_q + word_b_q;
    end
  end

  assign draw_o = draw_q;

endmodule

// ----- rtl/rpg_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpg_mod
// Multi-cycle remainder of a 64-bit word by a divisor of 1..64,
// restoring style, eight dividend bits per cycle.
// ----------------------------------------------------------------------------
module rpg_mod import rpg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [LenW-1:0]  divisor_i,
  output mod_status_t      status_o,
  output logic [IdxW-1:0]  rem_o
);

  logic [WordW-1:0] shift_q;
  logic [IdxW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  div_q;
  logic [$clog2(ModCycles)-1:0] cnt_q;
  logic             busy_q, done_q;

  // remainder stays below the divisor, so the shifted value fits LenW bits
  always_comb begin
    logic [LenW-1:0] t;
    rem_d = rem_q;
    for (int k = 0; k < ModBitsPerCyc; k++) begin
      t = {rem_d, shift_q[WordW-1-k]};
      if (t >= div_q) begin
        t = t - div_q;
      end
      rem_d = t[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 1'b1;
      if (cnt_q == ($clog2(ModCycles))'(ModCycles - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
      div_q   <= divisor_i;
    end else if (busy_q) begin
      shift_q <= shift_q << ModBitsPerCyc;
      rem_q   <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule

// ----- rtl/random_permutation_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_permutation_generator_unit
// Inside-out Fisher-Yates shuffle driven by a xoroshiro128+ generator.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the input channel (in_valid_i / in_stall_o) carries
//   perm_length_i. The block answers with a random permutation of
//   0..n-1 on the output channel (out_valid_o / out_stall_i), one index
//   per beat, is_last_o high on the final one. Lengths above 64 are
//   clamped to 64; a zero length is taken and produces nothing.
//   One request is in flight at a time; in_stall_o is high until the
//   last index has been taken.
//   Each shuffle step runs a draw check (a rejected draw is replaced by a
//   fresh one), the remainder unit and a read-modify-write on the
//   permutation RAM. Readout first reads the RAM, then gives one index
//   per cycle while not stalled.
//   Stalling the output holds the current index; nothing is lost.
//   Reset loads the generator with words 1 and 0; writes to the seed
//   registers (cfg_valid_i / cfg_ready_o) reload it, only while idle.
//   A pending seed write holds off a new request until it is taken.
//   The generator state carries over from one request to the next.
// ----------------------------------------------------------------------------
module random_permutation_generator_unit import rpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [LenW-1:0]    perm_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IdxW-1:0]    perm_index_o,
  output logic               is_last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  `include "random_permutation_generator_unit_macros.svh"

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StCheck   = 3'd1;
  localparam logic [2:0] StMod     = 3'd2;
  localparam logic [2:0] StMove    = 3'd3;
  localparam logic [2:0] StPlace   = 3'd4;
  localparam logic [2:0] StOutRd   = 3'd5;
  localparam logic [2:0] StOutWait = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] last_q, last_d;

  logic             advance;
  logic [WordW-1:0] draw;
  logic [WordW-1:0] limit;
  logic             mod_start;
  mod_status_t      mod_st;
  logic [IdxW-1:0]  rem;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [IdxW-1:0] ram_wdata, ram_rdata;

  logic in_acc, out_acc, cfg_we;
  logic req_go;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign req_go  = in_acc && (perm_length_i != '0);

  // draws at or above this bound would bias the remainder
  assign limit = {{(WordW-IdxW){1'b1}}, ~AllOnesMod[idx_q]};

  rpg_rng u_rng (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (advance),
    .draw_o      (draw)
  );

  rpg_mod u_mod (
    .clk_i,
    .rst_ni,
    .start_i    (mod_start),
    .dividend_i (draw),
    .divisor_i  ({1'b0, idx_q} + LenW'(1)),
    .status_o   (mod_st),
    .rem_o      (rem)
  );

  rpg_ram #(
    .Width (IdxW),
    .Depth (MaxLen)
  ) u_perm_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    last_d    = last_q;
    advance   = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    case (state_q)
      StIdle: begin
        if (req_go) begin
          last_d  = (perm_length_i > LenW'(MaxLen)) ? IdxW'(MaxLen - 1)
                                                    : IdxW'(perm_length_i - 1'b1);
          idx_d   = '0;
          advance = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (draw >= limit) begin
          advance = 1'b1;
        end else begin
          mod_start = 1'b1;
          state_d   = StMod;
        end
      end
      StMod: begin
        if (mod_st.done) begin
          ram_re    = 1'b1;
          ram_raddr = rem;
          state_d   = StMove;
        end
      end
      StMove: begin
        ram_we    = (rem != idx_q);
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        state_d   = StPlace;
      end
      StPlace: begin
        ram_we    = 1'b1;
        ram_waddr = rem;
        ram_wdata = idx_q;
        if (idx_q == last_q) begin
          idx_d   = '0;
          state_d = StOutRd;
        end else begin
          idx_d   = idx_q + 1'b1;
          advance = 1'b1;
          state_d = StCheck;
        end
      end
      StOutRd: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        state_d   = StOutWait;
      end
      StOutWait: begin
        if (out_acc) begin
          if (idx_q == last_q) begin
            state_d = StIdle;
          end else begin
            // fetch the next index on the same edge the current one leaves
            ram_re    = 1'b1;
            ram_raddr = idx_q + 1'b1;
            idx_d     = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  // a seed write goes first; the request is held off while cfg_valid_i is high
  assign in_stall_o   = (state_q != StIdle) || cfg_valid_i;
  assign out_valid_o  = (state_q == StOutWait);
  assign perm_index_o = ram_rdata;
  assign is_last_o    = (idx_q == last_q);
  assign cfg_ready_o  = (state_q == StIdle);

  `RPG_ASSERT(a_idx_in_range, (state_q != StIdle) |-> (idx_q <= last_q), "index past length")
  `RPG_ASSERT(a_rem_below_bound, mod_st.done |-> (rem <= idx_q), "remainder not below bound")
  `RPG_ASSERT(a_request_starts, req_go |=> (state_q == StCheck), "request not started")
  `RPG_ASSERT_NEVER(a_mod_idle_on_start, mod_start && mod_st.busy, "remainder unit restarted")

endmodule

// ----- tb/permutation_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_checker
// Watches the request, result and seed channels of the permutation
// generator. Keeps its own xoroshiro128+ state and shuffle memory, works out
// the permutation for every accepted request and compares each accepted
// index and last flag against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module permutation_checker import rpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [LenW-1:0]    perm_length_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [IdxW-1:0]    perm_index_i,
  input  logic               is_last_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        requests_o,
  output int unsigned        indices_o
);

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            last;
  } perm_beat_t;

  perm_beat_t       expected_beats[$];
  logic [WordW-1:0] gen_a;
  logic [WordW-1:0] gen_b;
  logic [IdxW-1:0]  shuffle_mem [MaxLen];
  int unsigned      fails;
  int unsigned      requests;
  int unsigned      indices;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned k);
    return (v << k) | (v >> (WordW - k));
  endfunction

  // one xoroshiro128+ step; advances gen_a / gen_b
  function automatic logic [WordW-1:0] xoro_draw();
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
    logic [WordW-1:0] sum;
    w0    = gen_a;
    w1    = gen_b;
    sum   = w0 + w1;
    w1    = w1 ^ w0;
    gen_a = rotl(w0, RotA) ^ w1 ^ (w1 << ShiftA);
    gen_b = rotl(w1, RotB);
    return sum;
  endfunction

  // unbiased draw in 0..bound-1 by rejection
  function automatic logic [IdxW-1:0] draw_below(input int unsigned bound);
    logic [WordW-1:0] all_ones;
    logic [WordW-1:0] lim;
    logic [WordW-1:0] r;
    all_ones = '1;
    lim      = (all_ones / WordW'(bound)) * WordW'(bound);
    r        = xoro_draw();
    while (r >= lim) r = xoro_draw();
    return IdxW'(r % WordW'(bound));
  endfunction

  task automatic predict_permutation(input logic [LenW-1:0] len_raw);
    int unsigned     n;
    logic [IdxW-1:0] j;
    perm_beat_t      beat;
    n = len_raw;
    if (n == 0) return;
    if (n > MaxLen) n = MaxLen;
    // inside-out shuffle
    shuffle_mem[0] = '0;
    for (int i = 0; i < n; i++) begin
      j = draw_below(i + 1);
      if (j != IdxW'(i)) shuffle_mem[i] = shuffle_mem[j];
      shuffle_mem[j] = IdxW'(i);
    end
    for (int i = 0; i < n; i++) begin
      beat.index = shuffle_mem[i];
      beat.last  = (i == n - 1);
      expected_beats.push_back(beat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    perm_beat_t exp_beat;
    if (!rst_ni) begin
      gen_a    = SeedLowRst;
      gen_b    = SeedHighRst;
      fails    = 0;
      requests = 0;
      indices  = 0;
      expected_beats.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      requests_o   <= 0;
      indices_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        indices++;
        if (expected_beats.size() == 0) begin
          fails++;
          $display("%0t: unexpected index, expected none, got index %0d last %0b",
                   $time, perm_index_i, is_last_i);
        end else begin
          exp_beat = expected_beats.pop_front();
          if (perm_index_i !== exp_beat.index) begin
            fails++;
            $display("%0t: perm_index mismatch, expected %0d, got %0d",
                     $time, exp_beat.index, perm_index_i);
          end
          if (is_last_i !== exp_beat.last) begin
            fails++;
            $display("%0t: is_last mismatch, expected %0b, got %0b",
                     $time, exp_beat.last, is_last_i);
          end
        end
      end
      // seed writes reload the generator; other indexes are ignored
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegSeedLow) begin
          gen_a = cfg_data_i;
        end else if (cfg_index_i == RegSeedHigh) begin
          gen_b = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        requests++;
        predict_permutation(perm_length_i);
      end
      fail_count_o <= fails;
      pending_o    <= expected_beats.size();
      requests_o   <= requests;
      indices_o    <= indices;
    end
  end

endmodule

// ----- tb/tb_random_permutation_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_permutation_generator_unit
// Drives permutation requests and seed writes into the generator, with
// bursty requests and a shifting stall pattern on the result side; a
// separate checker predicts every permutation and compares the results.
// ----------------------------------------------------------------------------
module tb_random_permutation_generator_unit;
  import rpg_pkg::*;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [WordW-1:0]   data;
  } cfg_write_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic [LenW-1:0]    perm_length_i = '0;
  logic               out_stall_i   = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [WordW-1:0]   cfg_data_i    = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [IdxW-1:0]    perm_index_o;
  logic               is_last_o;
  logic               cfg_ready_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned requests;
  int unsigned indices;
  int unsigned seed_settings = 1;

  random_permutation_generator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .perm_length_i (perm_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .perm_index_o  (perm_index_o),
    .is_last_o     (is_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  permutation_checker perm_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .perm_length_i (perm_length_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .perm_index_i  (perm_index_o),
    .is_last_i     (is_last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .requests_o    (requests),
    .indices_o     (indices)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb_random_permutation_generator_unit failed");
    $finish;
  end

  // result-side stall: phases of no stall, random stall and long stall runs
  initial begin : stall_pattern
    int unsigned mode;
    int unsigned span;
    int unsigned run;
    run = 0;
    forever begin
      mode = $urandom_range(2);
      span = $urandom_range(200, 40);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            out_stall_i <= 1'b0;
          end
          1: begin
            out_stall_i <= ($urandom_range(9) < 3);
          end
          default: begin
            if (run == 0 && $urandom_range(7) == 0) run = $urandom_range(12, 1);
            out_stall_i <= (run != 0);
            if (run != 0) run--;
          end
        endcase
      end
    end
  end

  function automatic cfg_write_t seed_write(input logic [CfgIdxW-1:0] idx,
                                            input logic [WordW-1:0] data);
    cfg_write_t w;
    w.idx  = idx;
    w.data = data;
    return w;
  endfunction

  // mostly short permutations, some up to full length, a few raw 7-bit values
  function automatic logic [LenW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return LenW'($urandom_range(12, 1));
    if (r < 80) return LenW'($urandom_range(40, 13));
    if (r < 92) return LenW'($urandom_range(64, 41));
    return LenW'($urandom_range(127));
  endfunction

  task automatic program_regs(input cfg_write_t writes[$]);
    foreach (writes[k]) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= writes[k].idx;
      cfg_data_i  <= writes[k].data;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    seed_settings++;
  endtask

  task automatic send_lengths(input logic [LenW-1:0] lens[$]);
    int unsigned burst_left;
    burst_left = $urandom_range(8, 1);
    foreach (lens[k]) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(20, 1)) @(posedge clk_i);
        burst_left = $urandom_range(8, 1);
      end
      in_valid_i    <= 1'b1;
      perm_length_i <= lens[k];
      do @(posedge clk_i); while (in_stall_o);
      burst_left--;
    end
    in_valid_i <= 1'b0;
  endtask

  // a zero-length request yields nothing, so allow some slack after the drain
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [LenW-1:0]  lens[$];
    cfg_write_t       regs[$];
    logic [WordW-1:0] lo_word;
    logic [WordW-1:0] hi_word;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset seeds; shortest, longest, zero and over-length requests
    lens = '{7'd1, 7'd2, 7'd3, 7'd0, 7'd64, 7'd65, 7'd127, 7'd63, 7'd16, 7'd5};
    send_lengths(lens);
    wait_drained();

    // all-zero generator; writes to unused indexes must not disturb it
    regs.delete();
    regs.push_back(seed_write(RegSeedLow, '0));
    regs.push_back(seed_write(RegSeedHigh, '0));
    regs.push_back(seed_write(CfgIdxW'(15), '1));
    regs.push_back(seed_write(CfgIdxW'(2), {$urandom, $urandom}));
    program_regs(regs);
    lens = '{7'd1, 7'd8, 7'd64, 7'd0};
    send_lengths(lens);
    wait_drained();

    regs.delete();
    regs.push_back(seed_write(RegSeedLow, '1));
    regs.push_back(seed_write(RegSeedHigh, '1));
    program_regs(regs);
    lens = '{7'd64, 7'd7, 7'd33};
    send_lengths(lens);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      lo_word = {$urandom, $urandom};
      hi_word = {$urandom, $urandom};
      if (ph == 2) lo_word = '1;
      if (ph == 4) hi_word = '0;
      regs.delete();
      regs.push_back(seed_write(CfgIdxW'($urandom_range(15, 2)), {$urandom, $urandom}));
      // some phases reload only one word and let the other carry over
      if (ph != 3) regs.push_back(seed_write(RegSeedLow, lo_word));
      if (ph != 1) regs.push_back(seed_write(RegSeedHigh, hi_word));
      program_regs(regs);
      lens.delete();
      repeat (80) lens.push_back(pick_length());
      send_lengths(lens);
      wait_drained();
    end

    $display("Covered %0d requests (lengths 0..127) and %0d checked indices",
             requests, indices);
    $display("over %0d generator seedings, incl. all-zero and all-ones states",
             seed_settings);
    if (fail_count == 0) begin
      $display("tb_random_permutation_generator_unit passed");
    end else begin
      $display("tb_random_permutation_generator_unit failed");
    end
    $finish;
  end

endmodule
